// ----- hdl/sbh_pkg.sv -----
// Shared types and constants for the spectrum bar history renderer.
// Used by the top level and the iterative divider; depends on nothing else.

package sbh_pkg;

  // Fixed field widths of the block's ports.
  localparam int COL_W      = 5;
  localparam int HEIGHT_W   = 4;
  localparam int LEVEL_W    = 8;
  localparam int HUE_W      = 8;
  localparam int PIX_W      = 8;
  localparam int HIST_LEN_W = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // History store: sixteen ring slots of thirty-two columns each.
  localparam int SLOT_W      = 4;
  localparam int STORE_AW    = SLOT_W + COL_W;
  localparam int STORE_DEPTH = 1 << STORE_AW;

  // Divider: an 8-bit dividend takes one quotient bit per cycle.
  localparam int DIV_ITER  = LEVEL_W;
  localparam int DIV_CNT_W = $clog2(DIV_ITER);

  // floor(x / 5) for x below 1024 is (x * 52429) >> 18.
  localparam int RECIP5_W     = 16;
  localparam int RECIP5_SHIFT = 18;
  localparam logic [RECIP5_W-1:0] RECIP5 = 16'd52429;
  localparam int SCALED_W     = LEVEL_W + 2;
  localparam int RECIP_PROD_W = SCALED_W + RECIP5_W;
  // Largest step times frames held: floor(255 * 4 / 5).
  localparam int MAX_BASE_LEVEL = 204;

  // Row bands for the hue.
  localparam logic [HEIGHT_W-1:0] MID_BAND_ROW  = 4'd4;
  localparam logic [HEIGHT_W-1:0] HIGH_BAND_ROW = 4'd6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIST_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_HUE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MID_HUE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_HUE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SATURATION  = 3'd5;

  // Register values after reset.
  localparam logic [LEVEL_W-1:0]    RST_BRIGHTNESS  = 8'd255;
  localparam logic [HIST_LEN_W-1:0] RST_HIST_LENGTH = 5'd4;
  localparam logic [HUE_W-1:0]      RST_LOW_HUE     = 8'd0;
  localparam logic [HUE_W-1:0]      RST_MID_HUE     = 8'd64;
  localparam logic [HUE_W-1:0]      RST_HIGH_HUE    = 8'd160;
  localparam logic [LEVEL_W-1:0]    RST_SATURATION  = 8'd255;

  typedef struct packed {
    logic                  start;
    logic [LEVEL_W-1:0]    dividend;
    logic [HIST_LEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- hdl/sbh_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Self-contained; no package needed.

module sbh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/sbh_divider.sv -----
// Restoring divider producing one quotient bit per cycle.
// Depends on sbh_pkg for the request and response structs.

module sbh_divider
  import sbh_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_t;

  div_state_t             state;
  logic [DIV_CNT_W-1:0]   cnt;
  logic [HIST_LEN_W-1:0]  rem;
  logic [LEVEL_W-1:0]     quo;
  logic [HIST_LEN_W-1:0]  divisor;
  logic                   done;
  logic [HIST_LEN_W:0]    trial;
  logic                   fits;
  logic [HIST_LEN_W-1:0]  rem_next;

  // Bring down the next dividend bit and try one subtraction.
  always_comb begin
    trial    = {rem, quo[LEVEL_W-1]};
    fits     = trial >= {1'b0, divisor};
    rem_next = fits ? HIST_LEN_W'(trial - {1'b0, divisor}) : trial[HIST_LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        DIV_IDLE: begin
          if (req.start) begin
            rem     <= '0;
            quo     <= req.dividend;
            divisor <= req.divisor;
            cnt     <= '0;
            state   <= DIV_RUN;
          end
        end
        DIV_RUN: begin
          rem <= rem_next;
          quo <= {quo[LEVEL_W-2:0], fits};
          cnt <= cnt + 1'b1;
          if (cnt == DIV_CNT_W'(DIV_ITER - 1)) begin
            done  <= 1'b1;
            state <= DIV_IDLE;
          end
        end
        default: begin
          state <= DIV_IDLE;
        end
      endcase
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ----- hdl/spectrum_bar_history_renderer.sv -----
// Spectrum bar history renderer: top level, sequencer and output register.
// Depends on sbh_pkg, sbh_ram (height history) and sbh_divider (level step).
//
//   Channel  Handshake               Payload
//   item     item_valid/item_ready   column, bar_height, frame_end
//   pixel    pixel_valid/pixel_ready pixel_index, hue, sat, level, last_write
//   cfg      cfg_valid/cfg_ready     cfg_index, cfg_data
//
// With older frames in use a request passes through acceptance, the serial divider that
// forms the level step, the history walk (a RAM read per older frame, the read latency and
// a hand-over) and then the pixel writes. With no older frame the walk is still entered;
// a column that writes nothing still passes through the emit phase.
// A column outside the matrix is accepted and dropped without leaving the idle state.
// Reset is synchronous and clears the ring pointer, frame count, sequencer and
// configuration; the history RAM is not cleared.
// A stalled pixel request holds the sequencer in its emit phase; a new item
// request may be taken while the last pixel of the previous one still waits.

module spectrum_bar_history_renderer
  import sbh_pkg::*;
#(
  parameter int MATRIX_WIDTH  = 32,
  parameter int MATRIX_HEIGHT = 8,
  parameter int HIST_MAX      = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // Item requests
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic [COL_W-1:0]      column,
  input  logic [HEIGHT_W-1:0]   bar_height,
  input  logic                  frame_end,
  // Pixel write requests
  output logic                  pixel_valid,
  input  logic                  pixel_ready,
  output logic [PIX_W-1:0]      pixel_index,
  output logic [HUE_W-1:0]      hue,
  output logic [LEVEL_W-1:0]    sat,
  output logic [LEVEL_W-1:0]    level,
  output logic                  last_write,
  // Configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ROW_W = $clog2(MATRIX_HEIGHT);

  typedef enum logic [1:0] {
    IDLE,
    DIV,
    HIST,
    EMIT
  } state_t;

  // Configuration registers.
  logic [LEVEL_W-1:0]    brightness;
  logic [HIST_LEN_W-1:0] hist_length;
  logic [HUE_W-1:0]      low_hue;
  logic [HUE_W-1:0]      mid_hue;
  logic [HUE_W-1:0]      high_hue;
  logic [LEVEL_W-1:0]    saturation;

  // Ring state.
  logic [SLOT_W-1:0]     frame_slot;
  logic [HIST_LEN_W-1:0] frames_held;

  // Per-request working registers.
  state_t                state;
  logic [COL_W-1:0]      cur_col;
  logic [HEIGHT_W-1:0]   cur_h;
  logic [SLOT_W-1:0]     cur_slot;
  logic [HIST_LEN_W-1:0] held;
  logic [LEVEL_W-1:0]    dividend;
  logic                  div_go;
  logic [LEVEL_W-1:0]    step;
  logic [LEVEL_W-1:0]    acc;
  logic [HIST_LEN_W-1:0] rd_left;
  logic                  rd_valid;
  logic [LEVEL_W-1:0]    row_level [MATRIX_HEIGHT];
  logic [MATRIX_HEIGHT-1:0] pend;

  // Accept-side logic.
  logic                    item_accept;
  logic                    col_ok;
  logic [HIST_LEN_W-1:0]   hl_eff;
  logic [HIST_LEN_W-1:0]   held_calc;
  logic [HIST_LEN_W-1:0]   held_inc;
  logic [HEIGHT_W-1:0]     h_clip;
  logic [RECIP_PROD_W-1:0] recip_prod;
  logic [MATRIX_HEIGHT-1:0] lit_mask;

  // History read path.
  logic [SLOT_W+1:0]     rd_slot_wide;
  logic [STORE_AW-1:0]   rd_addr;
  logic [HEIGHT_W-1:0]   rd_height;
  logic [LEVEL_W-1:0]    acc_sum;

  // Emit path.
  logic [ROW_W-1:0]         sel;
  logic [MATRIX_HEIGHT-1:0] pend_rest;
  logic [15:0]              idx_full;
  logic [HUE_W-1:0]         sel_hue;
  logic [HEIGHT_W-1:0]      sel_row;
  logic                     out_free;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign item_ready  = (state == IDLE);
  assign cfg_ready   = 1'b1;
  assign item_accept = item_valid && item_ready;
  assign out_free    = !pixel_valid || pixel_ready;

  // Frames in use: the current one plus those kept, limited by hist_length,
  // which itself is forced into the range one to HIST_MAX.
  always_comb begin
    if (hist_length == '0) begin
      hl_eff = HIST_LEN_W'(1);
    end else if (hist_length > HIST_LEN_W'(HIST_MAX)) begin
      hl_eff = HIST_LEN_W'(HIST_MAX);
    end else begin
      hl_eff = hist_length;
    end
    held_inc  = frames_held + 1'b1;
    held_calc = (held_inc > hl_eff) ? hl_eff : held_inc;
    h_clip    = (bar_height > HEIGHT_W'(MATRIX_HEIGHT)) ? HEIGHT_W'(MATRIX_HEIGHT)
                                                         : bar_height;
    col_ok    = 32'(column) < MATRIX_WIDTH;
    // floor(brightness * 4 / 5) by reciprocal multiplication.
    recip_prod = RECIP_PROD_W'({brightness, 2'b00}) * RECIP_PROD_W'(RECIP5);
    for (int y = 0; y < MATRIX_HEIGHT; y++) begin
      lit_mask[y] = h_clip > HEIGHT_W'(y);
    end
  end

  // Older frames are read oldest first; rd_left is the age of the next one.
  always_comb begin
    if ({2'b00, cur_slot} >= {1'b0, rd_left}) begin
      rd_slot_wide = {2'b00, cur_slot} - {1'b0, rd_left};
    end else begin
      rd_slot_wide = {2'b00, cur_slot} + (SLOT_W + 2)'(HIST_MAX) - {1'b0, rd_left};
    end
    rd_addr = {rd_slot_wide[SLOT_W-1:0], cur_col};
    acc_sum = acc + step;
  end

  // Lowest row still waiting, the serpentine index and the row's hue band.
  always_comb begin
    sel = '0;
    for (int y = MATRIX_HEIGHT - 1; y >= 0; y--) begin
      if (pend[y]) begin
        sel = ROW_W'(y);
      end
    end
    pend_rest      = pend;
    pend_rest[sel] = 1'b0;
    if (cur_col[0]) begin
      idx_full = 16'(MATRIX_HEIGHT) * (16'(MATRIX_WIDTH) - 16'(cur_col) - 16'd1)
                 + 16'(sel);
    end else begin
      idx_full = 16'(MATRIX_HEIGHT) * (16'(MATRIX_WIDTH) - 16'(cur_col))
                 - 16'(sel) - 16'd1;
    end
    sel_row = HEIGHT_W'(sel);
    if (sel_row > HIGH_BAND_ROW) begin
      sel_hue = high_hue;
    end else if (sel_row > MID_BAND_ROW) begin
      sel_hue = mid_hue;
    end else begin
      sel_hue = low_hue;
    end
  end

  sbh_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (item_accept && col_ok),
    .waddr ({frame_slot, column}),
    .wdata (h_clip),
    .raddr (rd_addr),
    .rdata (rd_height)
  );

  assign div_req.start    = div_go;
  assign div_req.dividend = dividend;
  assign div_req.divisor  = held;

  sbh_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Configuration registers; the user must write them only while the block is idle, as the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness  <= RST_BRIGHTNESS;
      hist_length <= RST_HIST_LENGTH;
      low_hue     <= RST_LOW_HUE;
      mid_hue     <= RST_MID_HUE;
      high_hue    <= RST_HIGH_HUE;
      saturation  <= RST_SATURATION;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BRIGHTNESS:  brightness  <= cfg_data;
        REG_HIST_LENGTH: hist_length <= cfg_data[HIST_LEN_W-1:0];
        REG_LOW_HUE:     low_hue     <= cfg_data;
        REG_MID_HUE:     mid_hue     <= cfg_data;
        REG_HIGH_HUE:    high_hue    <= cfg_data;
        REG_SATURATION:  saturation  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer, ring pointer and pixel output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      frame_slot  <= '0;
      frames_held <= '0;
      div_go      <= 1'b0;
      rd_valid    <= 1'b0;
      rd_left     <= '0;
      pend        <= '0;
      pixel_valid <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (pixel_ready) begin
        pixel_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (item_accept) begin
            // The ring moves on at once; the request keeps its own slot copy.
            if (frame_end) begin
              frame_slot  <= (frame_slot == SLOT_W'(HIST_MAX - 1)) ? '0
                                                                   : frame_slot + 1'b1;
              frames_held <= held_calc;
            end
            cur_col  <= column;
            cur_h    <= h_clip;
            cur_slot <= frame_slot;
            held     <= held_calc;
            dividend <= recip_prod[RECIP5_SHIFT +: LEVEL_W];
            acc      <= '0;
            rd_left  <= held_calc - 1'b1;
            rd_valid <= 1'b0;
            // Rows under the current bar take full brightness and win outright.
            for (int y = 0; y < MATRIX_HEIGHT; y++) begin
              row_level[y] <= brightness;
            end
            if (col_ok) begin
              pend   <= lit_mask;
              div_go <= 1'b1;
              state  <= DIV;
            end else begin
              pend <= '0;
            end
          end
        end
        DIV: begin
          if (div_rsp.done) begin
            step  <= div_rsp.quotient;
            state <= HIST;
          end
        end
        HIST: begin
          if (rd_left != '0) begin
            rd_left  <= rd_left - 1'b1;
            rd_valid <= 1'b1;
          end else begin
            rd_valid <= 1'b0;
          end
          // Frames arrive oldest first, so a newer frame overwrites an older one
          // on the rows they share; the current bar's rows are left alone.
          if (rd_valid) begin
            acc <= acc_sum;
            for (int y = 0; y < MATRIX_HEIGHT; y++) begin
              if (rd_height > HEIGHT_W'(y) && !(cur_h > HEIGHT_W'(y))) begin
                row_level[y] <= acc_sum;
                pend[y]      <= 1'b1;
              end
            end
          end
          if (rd_left == '0 && !rd_valid) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (pend == '0) begin
            state <= IDLE;
          end else if (out_free) begin
            pixel_valid <= 1'b1;
            pixel_index <= idx_full[PIX_W-1:0];
            hue         <= sel_hue;
            sat         <= saturation;
            level       <= row_level[sel];
            last_write  <= (pend_rest == '0);
            pend        <= pend_rest;
            if (pend_rest == '0) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // No row may still be waiting once the sequencer is back at rest.
  assert property (@(posedge clk) disable iff (rst) (state == IDLE) |-> (pend == '0))
    else $error("rows left pending while idle");

  // The history walk never reaches back past the oldest frame in use.
  assert property (@(posedge clk) disable iff (rst) (state == HIST) |-> (rd_left < held))
    else $error("history read age out of range");

  // The divided step times the frames held never exceeds four fifths of 255.
  assert property (@(posedge clk) disable iff (rst)
    (state == HIST) |-> ((13'(step) * 13'(held)) <= 13'(MAX_BASE_LEVEL)))
    else $error("level step too large for the frames held");

  // A column inside the matrix always starts the divider.
  assert property (@(posedge clk) disable iff (rst)
    (item_accept && col_ok) |=> (state == DIV && div_go))
    else $error("in-range column did not start the level step");

endmodule

// ----- verif/spectrum_bar_history_renderer_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for spectrum_bar_history_renderer.
// Depends on sbh_pkg and the RTL top level, which in turn needs sbh_ram and sbh_divider.

module spectrum_bar_history_renderer_tb;
  import sbh_pkg::*;

  localparam int MATRIX_WIDTH  = 32;
  localparam int MATRIX_HEIGHT = 8;
  localparam int HIST_MAX      = 16;

  // A column's whole passage through the block fits well within this, so it is ample for the
  // block to fall silent after its last pixel request.
  localparam int SETTLE_CYCLES   = 64;
  // The longest legitimate silence is the deliberate receiver hold-off of HOLD_CYCLES;
  // the watchdog allows more than ten times that before it declares the block hung.
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 30;

  typedef struct packed {
    logic [PIX_W-1:0]   idx;
    logic [HUE_W-1:0]   hue;
    logic [LEVEL_W-1:0] sat;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } pixel_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]    bright;
    logic [HIST_LEN_W-1:0] hist;
    logic [HUE_W-1:0]      lo;
    logic [HUE_W-1:0]      mid;
    logic [HUE_W-1:0]      hi;
    logic [LEVEL_W-1:0]    sat;
  } reg_set_t;

  // A row of the directed table. Rows marked typed carry their own expectation: the
  // number of lit rows, the LED index of row 0 and whether the index climbs with the row.
  typedef struct packed {
    logic [COL_W-1:0]    col;
    logic [HEIGHT_W-1:0] h;
    logic                fe;
    logic                typed;
    logic [3:0]          n_px;
    logic [PIX_W-1:0]    idx0;
    logic                ascending;
  } dir_row_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  // The first frame after reset has no history behind it, so every lit row is at full
  // reset brightness and its index can be read straight off the serpentine layout. The
  // later frames reuse the same six columns, mostly with lower bars, so the older frames
  // show through as graded levels.
  localparam dir_row_t DIR_ROWS [24] = '{
    '{5'd0,  4'd15, 1'b0, 1'b1, 4'd8, 8'd255, 1'b0},   // tall bar, clipped to the matrix
    '{5'd31, 4'd8,  1'b0, 1'b1, 4'd8, 8'd0,   1'b1},   // last column, full height
    '{5'd1,  4'd0,  1'b0, 1'b1, 4'd0, 8'd0,   1'b1},   // empty bar, no writes
    '{5'd5,  4'd3,  1'b0, 1'b1, 4'd3, 8'd208, 1'b1},
    '{5'd16, 4'd1,  1'b0, 1'b1, 4'd1, 8'd127, 1'b0},
    '{5'd2,  4'd4,  1'b1, 1'b1, 4'd4, 8'd239, 1'b0},   // end of frame
    '{5'd0,  4'd2,  1'b0, 1'b0, 4'd0, 8'd0,   1'b0},
    '{5'd31, 4'd0,  1'b0, 1'b0, 4'd0, 8'd0,   1'b0},
    '{5'd1,  4'd3,  1'b0, 1'b0, 4'd0, 8'd0,   1'b0},
    '{5'd5,  4'd1,  1'b0, 1'b0, 4'd0, 8'd0,   1'b0},
    '{5'd16, 4'd0,  1'b0, 1'b0, 4'd0, 8'd0,   1'b0},
    '{5'd2,  4'd15, 1'b1, 1'b0, 4'd0, 8'd0,   1'b0},
    '{5'd0,  4'd0,  1'b0, 1'b0, 4'd0, 8'd0,   1'b0},
    '{5'd31, 4'd0,  1'b0, 1'b0, 4'd0, 8'd0,   1'b0},
    '{5'd1,  4'd0,  1'b0, 1'b0, 4'd0, 8'd0,   1'b0},
    '{5'd5,  4'd0,  1'b0, 1'b0, 4'd0, 8'd0,   1'b0},
    '{5'd16, 4'd0,  1'b0, 1'b0, 4'd0, 8'd0,   1'b0},
    '{5'd2,  4'd0,  1'b1, 1'b0, 4'd0, 8'd0,   1'b0},
    '{5'd0,  4'd1,  1'b0, 1'b0, 4'd0, 8'd0,   1'b0},
    '{5'd31, 4'd0,  1'b0, 1'b0, 4'd0, 8'd0,   1'b0},
    '{5'd1,  4'd0,  1'b0, 1'b0, 4'd0, 8'd0,   1'b0},
    '{5'd5,  4'd0,  1'b0, 1'b0, 4'd0, 8'd0,   1'b0},
    '{5'd16, 4'd0,  1'b0, 1'b0, 4'd0, 8'd0,   1'b0},
    '{5'd2,  4'd0,  1'b1, 1'b0, 4'd0, 8'd0,   1'b0}
  };

  // Register settings for the first phases: both brightness extremes, a zero level step
  // with history present, and frame counts of one, sixteen, zero and above sixteen.
  localparam reg_set_t FIXED_SETS [6] = '{
    '{8'd255, 5'd16, 8'd0,   8'd255, 8'd128, 8'd0},
    '{8'd0,   5'd1,  8'd255, 8'd0,   8'd1,   8'd255},
    '{8'd3,   5'd4,  8'd17,  8'd34,  8'd51,  8'd200},
    '{8'd128, 5'd0,  8'd90,  8'd180, 8'd10,  8'd77},
    '{8'd255, 5'd31, 8'd255, 8'd255, 8'd255, 8'd255},
    '{8'd1,   5'd17, 8'd0,   8'd0,   8'd0,   8'd1}
  };

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  item_valid  = 1'b0;
  logic                  item_ready;
  logic [COL_W-1:0]      column      = '0;
  logic [HEIGHT_W-1:0]   bar_height  = '0;
  logic                  frame_end   = 1'b0;
  logic                  pixel_valid;
  logic                  pixel_ready = 1'b0;
  logic [PIX_W-1:0]      pixel_index;
  logic [HUE_W-1:0]      hue;
  logic [LEVEL_W-1:0]    sat;
  logic [LEVEL_W-1:0]    level;
  logic                  last_write;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  // Pixel writes still owed by the block, oldest first.
  pixel_t   pending_px[$];
  int       errors   = 0;
  rx_mode_t rx_mode  = RX_ALWAYS;
  int       hold_req = 0;

  // Shadow of the block's registers and history, updated as requests are accepted.
  logic [LEVEL_W-1:0]    cfg_bright = RST_BRIGHTNESS;
  logic [HIST_LEN_W-1:0] cfg_hist   = RST_HIST_LENGTH;
  logic [HUE_W-1:0]      cfg_lo     = RST_LOW_HUE;
  logic [HUE_W-1:0]      cfg_mid    = RST_MID_HUE;
  logic [HUE_W-1:0]      cfg_hi     = RST_HIGH_HUE;
  logic [LEVEL_W-1:0]    cfg_sat    = RST_SATURATION;
  logic [HEIGHT_W-1:0]   hist_mem     [STORE_DEPTH];
  bit                    hist_written [STORE_DEPTH];
  logic [SLOT_W-1:0]     cur_slot    = '0;
  logic [HIST_LEN_W-1:0] frames_kept = '0;
  logic [LEVEL_W-1:0]    step_lvl    = '0;

  spectrum_bar_history_renderer #(
    .MATRIX_WIDTH  (MATRIX_WIDTH),
    .MATRIX_HEIGHT (MATRIX_HEIGHT),
    .HIST_MAX      (HIST_MAX)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .column      (column),
    .bar_height  (bar_height),
    .frame_end   (frame_end),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel_index (pixel_index),
    .hue         (hue),
    .sat         (sat),
    .level       (level),
    .last_write  (last_write),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #4 clk = ~clk;

  // Frames in use for the next column: the frames kept so far plus the current one,
  // capped by the frame-count register, which itself is forced into 1..HIST_MAX.
  function automatic int held_now();
    int lim;
    int held;
    lim = int'(cfg_hist);
    if (lim < 1) lim = 1;
    if (lim > HIST_MAX) lim = HIST_MAX;
    held = int'(frames_kept) + 1;
    if (held > lim) held = lim;
    return held;
  endfunction

  // True when every older frame the column could look back at has been written for it.
  function automatic bit history_safe(input logic [COL_W-1:0] col);
    int                held;
    logic [SLOT_W-1:0] slot;
    held = held_now();
    for (int k = 1; k < held; k++) begin
      slot = cur_slot - SLOT_W'(k);
      if (!hist_written[{slot, col}]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Works out the pixel writes one column request causes, and moves the history on.
  task automatic render_column(input logic [COL_W-1:0] col, input logic [HEIGHT_W-1:0] h_in,
                               input logic fe, output pixel_t px[$]);
    int                held;
    int                hc;
    int                lvl;
    int                idx;
    int                c;
    bit                hit;
    logic [SLOT_W-1:0] slot;
    pixel_t            p;
    px = {};
    held = held_now();
    step_lvl = LEVEL_W'((int'(cfg_bright) * 4 / 5) / held);
    hc = (int'(h_in) > MATRIX_HEIGHT) ? MATRIX_HEIGHT : int'(h_in);
    hist_mem[{cur_slot, col}] = HEIGHT_W'(hc);
    hist_written[{cur_slot, col}] = 1'b1;
    c = int'(col);
    for (int y = 0; y < MATRIX_HEIGHT; y++) begin
      hit = 1'b0;
      lvl = 0;
      if (hc > y) begin
        lvl = int'(cfg_bright);
        hit = 1'b1;
      end else begin
        // Newest older frame first; the oldest frame in use gets one step.
        for (int k = 1; k < held && !hit; k++) begin
          slot = cur_slot - SLOT_W'(k);
          if (int'(hist_mem[{slot, col}]) > y) begin
            lvl = int'(step_lvl) * (held - k);
            hit = 1'b1;
          end
        end
      end
      if (hit) begin
        // Odd columns run upward along the strip, even columns downward.
        if (col[0]) idx = MATRIX_HEIGHT * (MATRIX_WIDTH - (c + 1)) + y;
        else idx = MATRIX_HEIGHT * (MATRIX_WIDTH - c) - (y + 1);
        p.idx = idx[PIX_W-1:0];
        if (y > int'(HIGH_BAND_ROW)) p.hue = cfg_hi;
        else if (y > int'(MID_BAND_ROW)) p.hue = cfg_mid;
        else p.hue = cfg_lo;
        p.sat   = cfg_sat;
        p.level = lvl[LEVEL_W-1:0];
        p.last  = 1'b0;
        px.insert(px.size(), p);
      end
    end
    if (px.size() > 0) px[px.size()-1].last = 1'b1;
    if (fe) begin
      cur_slot    = cur_slot + 1'b1;  // wraps round the sixteen slots
      frames_kept = HIST_LEN_W'(held);
    end
  endtask

  // Offers one column request and holds it until accepted. Valid is left high so that a
  // following request can go out back to back; callers lower it when they pause.
  task automatic send_item(input logic [COL_W-1:0] col, input logic [HEIGHT_W-1:0] h,
                           input logic fe, output pixel_t px[$]);
    item_valid <= 1'b1;
    column     <= col;
    bar_height <= h;
    frame_end  <= fe;
    do @(posedge clk); while (!item_ready);
    render_column(col, h, fe, px);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BRIGHTNESS:  cfg_bright = val;
      REG_HIST_LENGTH: cfg_hist   = val[HIST_LEN_W-1:0];
      REG_LOW_HUE:     cfg_lo     = val;
      REG_MID_HUE:     cfg_mid    = val;
      REG_HIGH_HUE:    cfg_hi     = val;
      REG_SATURATION:  cfg_sat    = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input reg_set_t s);
    write_reg(REG_BRIGHTNESS,  s.bright);
    write_reg(REG_HIST_LENGTH, CFG_DATA_W'(s.hist));
    write_reg(REG_LOW_HUE,     s.lo);
    write_reg(REG_MID_HUE,     s.mid);
    write_reg(REG_HIGH_HUE,    s.hi);
    write_reg(REG_SATURATION,  s.sat);
    cfg_valid <= 1'b0;
  endtask

  // Stops offering requests, waits for every owed pixel write and then lets the block
  // finish any column that writes nothing.
  task automatic drain();
    item_valid <= 1'b0;
    while (pending_px.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // Receiver: checks each accepted pixel request against the oldest expectation and
  // chooses the next value of ready. A hold-off request from the stimulus keeps ready low
  // for HOLD_CYCLES, counted here, so the block backs up and stalls its column input.
  always @(posedge clk) begin : pixel_sink
    pixel_t want;
    int     hold_left;
    int     hold_seen;
    int     pat_left;
    bit     pat_on;
    if (!rst && pixel_valid && pixel_ready) begin
      if (pending_px.size() == 0) begin
        errors++;
        $display("%0t: pixel write to index %0d with none expected", $time, pixel_index);
      end else begin
        want = pending_px[0];
        pending_px.delete(0);
        check_field("pixel_index", want.idx, pixel_index);
        check_field("hue", want.hue, hue);
        check_field("sat", want.sat, sat);
        check_field("level", want.level, level);
        check_field("last_write", 8'(want.last), 8'(last_write));
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      pixel_ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES - 1;
      pixel_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_RANDOM: pixel_ready <= ($urandom_range(0, 2) != 0);
        RX_PATTERN: begin
          if (pat_left == 0) begin
            pat_on   = !pat_on;
            pat_left = pat_on ? $urandom_range(1, 10) : $urandom_range(1, 5);
          end
          pat_left--;
          pixel_ready <= pat_on;
        end
        default: pixel_ready <= 1'b1;
      endcase
    end
  end

  // Watchdog: any cycle without an accepted request on some channel counts towards the limit.
  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if ((item_valid && item_ready) || (pixel_valid && pixel_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    pixel_t           px[$];
    pixel_t           p;
    reg_set_t         rs;
    logic [COL_W-1:0] col;
    logic [HEIGHT_W-1:0] h;
    logic             fe;
    int               win_base;
    int               win_width;
    int               win_pos;
    int               burst_left;
    int               gap;
    bit               gaps_on;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: walk the table, with a randomly stalling receiver.
    rx_mode = RX_RANDOM;
    foreach (DIR_ROWS[i]) begin
      send_item(DIR_ROWS[i].col, DIR_ROWS[i].h, DIR_ROWS[i].fe, px);
      if (DIR_ROWS[i].typed) begin
        px = {};
        for (int y = 0; y < DIR_ROWS[i].n_px; y++) begin
          p.idx = DIR_ROWS[i].ascending ? DIR_ROWS[i].idx0 + PIX_W'(y)
                                        : DIR_ROWS[i].idx0 - PIX_W'(y);
          p.hue = (y > 6) ? RST_HIGH_HUE : (y > 4) ? RST_MID_HUE : RST_LOW_HUE;
          p.sat   = RST_SATURATION;
          p.level = RST_BRIGHTNESS;
          p.last  = (y == DIR_ROWS[i].n_px - 1);
          px.insert(px.size(), p);
        end
      end
      foreach (px[j]) pending_px.insert(pending_px.size(), px[j]);
    end

    // Random part: phases of well-formed frames over a window of columns, which tends
    // to stay put so that deep history builds up, salted with stray requests. Each
    // phase starts from an idle block with fresh register settings.
    win_base   = 0;
    win_width  = 4;
    win_pos    = 0;
    burst_left = 0;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      if (phase < 6) begin
        rs = FIXED_SETS[phase];
      end else begin
        rs.bright = LEVEL_W'($urandom_range(0, 255));
        rs.hist   = HIST_LEN_W'($urandom_range(0, 31));
        rs.lo     = HUE_W'($urandom_range(0, 255));
        rs.mid    = HUE_W'($urandom_range(0, 255));
        rs.hi     = HUE_W'($urandom_range(0, 255));
        rs.sat    = LEVEL_W'($urandom_range(0, 255));
      end
      apply_settings(rs);
      rx_mode = rx_mode_t'(phase % 3);
      gaps_on = (phase % 4) != 0;
      // Once, the receiver goes quiet for a long stretch while requests keep coming.
      if (phase == 2) hold_req++;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (gaps_on && burst_left == 0) begin
          gap = $urandom_range(0, 6);
          if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;

        if ($urandom_range(0, 9) == 0) begin
          // Stray request: any column, any height, frame end at random.
          col = COL_W'($urandom_range(0, 31));
          h   = HEIGHT_W'($urandom_range(0, 15));
          fe  = 1'($urandom_range(0, 1));
        end else begin
          if (win_pos == 0 && $urandom_range(0, 3) == 0) begin
            win_base  = $urandom_range(0, 31);
            win_width = ($urandom_range(0, 7) == 0) ? MATRIX_WIDTH : $urandom_range(1, 8);
          end
          col = COL_W'((win_base + win_pos) % MATRIX_WIDTH);
          h   = HEIGHT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                                                      : $urandom_range(0, 8));
          fe  = (win_pos == win_width - 1);
          win_pos = fe ? 0 : win_pos + 1;
        end
        // A bar lower than the matrix looks back through older frames; where one of them
        // never held this column, a full-height bar is sent instead so the look-back
        // never happens.
        if (int'(h) < MATRIX_HEIGHT && !history_safe(col)) begin
          h = HEIGHT_W'($urandom_range(8, 15));
        end

        send_item(col, h, fe, px);
        foreach (px[j]) pending_px.insert(pending_px.size(), px[j]);
      end
    end

    drain();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
